FILE: design/k_equal_sum_partition_check_unit_assert.svh
// Assertion macros shared by the partition check unit.
`ifndef K_EQUAL_SUM_PARTITION_CHECK_UNIT_ASSERT_SVH
`define K_EQUAL_SUM_PARTITION_CHECK_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define KESP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kesp: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define KESP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kesp: next-cycle check failed");

`endif

FILE: design/kesp_pkg.sv
package kesp_pkg;

    localparam int CFG_W            = 5;
    localparam int IN_DATA_W        = 16;
    localparam int OUT_DATA_W       = 8;
    localparam int OUT_POSS_BIT     = 0;
    localparam int OUT_TOO_MANY_BIT = 1;

    typedef struct packed {
        logic load;       // input word accepted
        logic div_start;  // start total / num_parts
        logic clr_step;   // clear one table entry
        logic mask_rd;    // read table entry of current mask
        logic scan;       // try one element on current mask
        logic mask_next;  // advance to next mask
        logic out_load;   // load result register
        logic out_poss;   // result value for out_load
    } ctrl_cmd_t;

    typedef struct packed {
        logic np_one;
        logic np_zero;
        logic div_busy;
        logic rem_zero;
        logic mask_full;
        logic ent_valid;
        logic elem_last;
        logic full_ok;
        logic out_free;
    } dp_status_t;

endpackage

FILE: design/kesp_ram.sv
module kesp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/kesp_div.sv
module kesp_div #(
    parameter int DIVIDEND_W = 21
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  logic [kesp_pkg::CFG_W-1:0] divisor,
    output logic                   busy,
    output logic [DIVIDEND_W-1:0]  quotient,
    output logic [kesp_pkg::CFG_W-1:0] remainder
);
    import kesp_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CFG_W-1:0]      rem_reg, rem_next;
    logic [CFG_W-1:0]      den_reg, den_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    logic [CFG_W:0] trial;
    logic [CFG_W:0] diff;
    logic           ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next  = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: design/kesp_dp.sv
`include "k_equal_sum_partition_check_unit_assert.svh"

module kesp_dp #(
    parameter int MAX_ITEMS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [kesp_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic [kesp_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [kesp_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  kesp_pkg::ctrl_cmd_t                 cmd,
    output kesp_pkg::dp_status_t                st
);
    import kesp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int SUM_W  = VALUE_BITS + CNT_W;
    localparam int MASK_W = MAX_ITEMS;
    localparam int DEPTH  = 1 << MAX_ITEMS;

    logic [CFG_W-1:0]      num_parts_reg, num_parts_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  ovf_reg, ovf_next;
    logic [MASK_W-1:0]     m_reg, m_next;
    logic [IDX_W-1:0]      e_reg, e_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [VALUE_BITS-1:0] store_reg [MAX_ITEMS];

    logic [VALUE_BITS-1:0] value_in;
    logic                  has_room;
    logic [MASK_W-1:0]     full_mask;
    logic [MASK_W-1:0]     elem_bit;

    logic                  div_busy;
    logic [SUM_W-1:0]      bucket;
    logic [CFG_W-1:0]      remainder;

    logic                  ram_we;
    logic [MASK_W-1:0]     ram_waddr;
    logic [SUM_W:0]        ram_wdata;
    logic [SUM_W:0]        ram_rdata;

    logic                  ent_valid;
    logic [SUM_W-1:0]      ent_res;
    logic [SUM_W:0]        r_sum;
    logic [SUM_W-1:0]      res_new;
    logic                  wr_ok;

    assign value_in  = VALUE_BITS'(s_tdata);
    assign has_room  = count_reg < CNT_W'(MAX_ITEMS);
    assign full_mask = (count_reg >= CNT_W'(MAX_ITEMS)) ? '1 :
                       ((MASK_W'(1) << count_reg) - MASK_W'(1));
    assign elem_bit  = MASK_W'(1) << e_reg;

    assign ent_valid = ram_rdata[SUM_W];
    assign ent_res   = ram_rdata[SUM_W-1:0];
    assign r_sum     = {1'b0, ent_res} + (SUM_W + 1)'(store_reg[e_reg]);
    assign res_new   = (r_sum == {1'b0, bucket}) ? '0 : r_sum[SUM_W-1:0];
    assign wr_ok     = ent_valid && !m_reg[e_reg] && (r_sum <= {1'b0, bucket});

    // clearing writes entry 0 as valid with residue zero and every other entry as invalid
    assign ram_we    = cmd.clr_step || (cmd.scan && wr_ok);
    assign ram_waddr = cmd.clr_step ? m_reg : (m_reg | elem_bit);
    assign ram_wdata = cmd.clr_step ? {m_reg == '0, {SUM_W{1'b0}}} : {1'b1, res_new};

    kesp_div #(
        .DIVIDEND_W(SUM_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (sum_reg),
        .divisor   (num_parts_reg),
        .busy      (div_busy),
        .quotient  (bucket),
        .remainder (remainder)
    );

    kesp_ram #(
        .WIDTH (SUM_W + 1),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.mask_rd),
        .raddr (m_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        num_parts_next = cfg_wr_en ? cfg_wr_data : num_parts_reg;

        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        priority if (cmd.out_load) begin
            count_next = '0;
            sum_next   = '0;
            ovf_next   = 1'b0;
        end else if (cmd.load && has_room) begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + SUM_W'(value_in);
        end else if (cmd.load) begin
            ovf_next = 1'b1;
        end else begin
            count_next = count_reg;
        end

        m_next = m_reg;
        priority if (cmd.out_load) begin
            m_next = '0;
        end else if (cmd.clr_step) begin
            m_next = (m_reg == full_mask) ? '0 : m_reg + MASK_W'(1);
        end else if (cmd.mask_next) begin
            m_next = m_reg + MASK_W'(1);
        end else begin
            m_next = m_reg;
        end

        e_next = e_reg;
        priority if (cmd.mask_rd) begin
            e_next = '0;
        end else if (cmd.scan) begin
            e_next = e_reg + IDX_W'(1);
        end else begin
            e_next = e_reg;
        end

        m_tvalid_next = m_tvalid_reg;
        priority if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end

        m_tdata_next = m_tdata_reg;
        if (cmd.out_load) begin
            m_tdata_next                   = '0;
            m_tdata_next[OUT_POSS_BIT]     = cmd.out_poss;
            m_tdata_next[OUT_TOO_MANY_BIT] = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_parts_reg <= CFG_W'(1);
            count_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            m_reg         <= '0;
            e_reg         <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            num_parts_reg <= num_parts_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            m_reg         <= m_next;
            e_reg         <= e_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (cmd.load && has_room) begin
            store_reg[count_reg[IDX_W-1:0]] <= value_in;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        st.np_one    = num_parts_reg == CFG_W'(1);
        st.np_zero   = num_parts_reg == '0;
        st.div_busy  = div_busy;
        st.rem_zero  = remainder == '0;
        st.mask_full = m_reg == full_mask;
        st.ent_valid = ent_valid;
        st.elem_last = (CNT_W'(e_reg) + CNT_W'(1)) == count_reg;
        st.full_ok   = ent_valid && (ent_res == '0);
        st.out_free  = !m_tvalid_reg || m_tready;
    end

    // a delivered result always starts the next set from empty
    `KESP_ASSERT_NXT(a_set_cleared, aclk, aresetn, cmd.out_load,
        (count_reg == '0) && (sum_reg == '0) && !ovf_reg)

endmodule

FILE: design/kesp_ctrl.sv
`include "k_equal_sum_partition_check_unit_assert.svh"

module kesp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    input  kesp_pkg::dp_status_t st,
    output kesp_pkg::ctrl_cmd_t  cmd
);
    import kesp_pkg::*;

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       poss_reg, poss_next;

    assign s_tready = state_reg == S_LOAD;

    always_comb begin
        state_next = state_reg;
        poss_next  = poss_reg;
        cmd        = '0;
        cmd.load   = s_tvalid && s_tready;
        unique case (state_reg)
            S_LOAD: begin
                if (cmd.load && s_tlast) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (st.np_one) begin
                    poss_next  = 1'b1;
                    state_next = S_DONE;
                end else if (st.np_zero) begin
                    poss_next  = 1'b0;
                    state_next = S_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (!st.div_busy) begin
                    if (!st.rem_zero) begin
                        poss_next  = 1'b0;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (st.mask_full) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd.mask_rd = 1'b1;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                if (st.mask_full) begin
                    poss_next  = st.full_ok;
                    state_next = S_DONE;
                end else begin
                    cmd.scan = 1'b1;
                    // invalid masks are skipped after one look
                    if (!st.ent_valid || st.elem_last) begin
                        cmd.mask_next = 1'b1;
                        state_next    = S_RD;
                    end
                end
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_poss = poss_reg;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            poss_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            poss_reg  <= poss_next;
        end
    end

    `KESP_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load, st.out_free)
    `KESP_ASSERT_IMP(a_div_needed, aclk, aresetn, cmd.div_start,
        !st.np_one && !st.np_zero)
    `KESP_ASSERT_IMP(a_load_idle, aclk, aresetn, cmd.load,
        !st.div_busy && !cmd.clr_step && !cmd.scan)

endmodule

FILE: design/k_equal_sum_partition_check_unit.sv
// channel | dir | handshake           | payload
// s_      | in  | s_tvalid / s_tready | s_tdata[15:0] value, s_tlast last
// m_      | out | m_tvalid / m_tready | m_tdata[0] possible, m_tdata[1] too_many
// cfg_    | in  | cfg_wr_en           | cfg_wr_data num_parts
//
// Values load one word per cycle while s_tready is high. The last word starts a decide step;
// for num_parts >= 2 a divide follows and, if it leaves no remainder, a clear of the 2^n
// table entries (n = stored values) and a sweep that tries each stored value on every
// reachable mask below the full one and skips the rest, paced by the table's single read port.
// Reset is synchronous, active low. s_tready is low from the last word until its result
// sits in the output register; a stalled m_ side holds it and delays the next result.
module k_equal_sum_partition_check_unit #(
    parameter int MAX_ITEMS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kesp_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kesp_pkg::IN_DATA_W-1:0]  s_tdata,   // [15:0] value
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kesp_pkg::OUT_DATA_W-1:0] m_tdata    // [0] possible, [1] too_many
);
    import kesp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    kesp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    kesp_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .st          (st)
    );

endmodule
